FILE: sv/smh_pkg.sv
// ----------------------------------------------------------------------------
// smh_pkg
// Shared types, codes and coil table for the stepper homing controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smh_pkg;

    localparam int PHASE_STEPS = 8;
    localparam int INDEX_COUNT = 16;

    localparam logic [3:0]  PHASE_NONE    = 4'hF;
    localparam logic [3:0]  COIL_KEEP     = 4'hA;
    localparam logic [3:0]  COIL_RELEASE  = 4'h5;
    localparam logic [15:0] THRESH_RESET  = 16'd40;
    localparam logic [11:0] SPI_RESET     = 12'd400;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_INDEX = 2'd2,
        KIND_STALL = 2'd3
    } kind_t;

    // move modes carried on a start item
    typedef enum logic [1:0] {
        MOVE_NORMAL  = 2'd0,
        MOVE_SEARCH  = 2'd1,
        MOVE_CROSS   = 2'd2,
        MOVE_INVALID = 2'd3
    } move_mode_t;

    // motor modes as reported
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NORMAL = 3'd1,
        MODE_SEARCH = 3'd2,
        MODE_CROSS  = 3'd3,
        MODE_STALL  = 3'd4
    } motor_mode_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_STEPS_PER_INDEX = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               home_sensor;
        logic signed [15:0] move_steps;
        logic [1:0]         move_mode;
        logic [3:0]         target_index;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic [2:0]         motor_mode;
        logic signed [15:0] position;
        logic               homed;
        logic               home_error;
        logic               is_idle;
    } out_item_t;

    typedef struct packed {
        logic [15:0] zero_count_threshold;
        logic [11:0] steps_per_index;
    } cfg_t;

    function automatic logic [3:0] coil_lookup(input logic [2:0] ph);
        logic [3:0] c;
        begin
            case (ph)
                3'd0:    c = 4'h6;
                3'd1:    c = 4'h5;
                3'd2:    c = 4'h4;
                3'd3:    c = 4'h8;
                3'd4:    c = 4'h0;
                3'd5:    c = 4'h3;
                3'd6:    c = 4'h2;
                3'd7:    c = 4'hE;
                default: c = 4'h0;
            endcase
            return c;
        end
    endfunction

    // next phase for one half step; an unset phase starts at either end
    function automatic logic [3:0] phase_advance(input logic [3:0] ph, input logic rev);
        logic [3:0] last;
        logic [3:0] nx;
        begin
            last = 4'(PHASE_STEPS - 1);
            if (!rev)
            begin
                if (ph == PHASE_NONE || ph >= last)
                    nx = 4'd0;
                else
                    nx = ph + 4'd1;
            end
            else
            begin
                if (ph == PHASE_NONE || ph == 4'd0 || ph > last)
                    nx = last;
                else
                    nx = ph - 4'd1;
            end
            return nx;
        end
    endfunction

    function automatic logic [3:0] sat_index(input logic [3:0] idx);
        logic [3:0] r;
        begin
            if (int'(idx) >= INDEX_COUNT)
                r = 4'(INDEX_COUNT - 1);
            else
                r = idx;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/stepper_motion_homing_controller.sv
// ----------------------------------------------------------------------------
// stepper_motion_homing_controller
// Half-step bipolar stepper sequencer with search and cross homing moves.
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register, then the result register
// throughput: 1 item per cycle while out_ready is high, bounded by the motion state update
// a waiting result stalls input only once the input register is also full
// reset: async active low; motor idle, coils off, position zero, phase unset,
// threshold 40 and steps per index 400
`timescale 1ns / 1ps
`default_nettype none

module stepper_motion_homing_controller
    import smh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t result;

    // item moves into the result register when that slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    smh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smh_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: sv/smh_cfg.sv
// ----------------------------------------------------------------------------
// smh_cfg
// APB register file: home crossing threshold and steps per index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smh_cfg
    import smh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [15:0] thresh_reg;
    logic [11:0] spi_reg;
    logic        wr_en;
    reg_index_t  sel;

    assign sel    = reg_index_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            spi_reg    <= SPI_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_THRESHOLD:       thresh_reg <= pwdata[15:0];
                REG_STEPS_PER_INDEX: spi_reg    <= pwdata[11:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_THRESHOLD:       prdata = {16'd0, thresh_reg};
            REG_STEPS_PER_INDEX: prdata = {20'd0, spi_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.zero_count_threshold = thresh_reg;
    assign cfg.steps_per_index      = spi_reg;

endmodule

`default_nettype wire

FILE: sv/smh_core.sv
// ----------------------------------------------------------------------------
// smh_core
// Motion state and the single-pass next-state logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smh_core
    import smh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    motor_mode_t mode_reg,   mode_next;
    logic        dir_reg,    dir_next;
    logic [15:0] stm_reg,    stm_next;
    logic [15:0] done_reg,   done_next;
    logic [15:0] pos_reg,    pos_next;
    logic [15:0] hits_reg,   hits_next;
    logic [3:0]  phase_reg,  phase_next;
    logic [3:0]  coil_reg,   coil_next;
    logic        homed_reg,  homed_next;
    logic        err_reg,    err_next;

    logic [3:0]  step_phase;
    logic [15:0] step_done;
    logic [15:0] step_pos;
    logic        done_hit;
    logic        stm_nz;
    logic        active;
    logic [15:0] hits_inc;
    logic [3:0]  tgt;
    logic [15:0] prod;
    logic [15:0] idx_count;
    logic        do_step;
    logic        do_pos;
    logic        do_release;
    logic        fin;

    assign step_phase = phase_advance(phase_reg, dir_reg);
    assign step_done  = dir_reg ? (done_reg - 16'd1) : (done_reg + 16'd1);
    assign step_pos   = dir_reg ? (pos_reg - 16'd1) : (pos_reg + 16'd1);
    assign done_hit   = (step_done == stm_reg);
    assign stm_nz     = (stm_reg != 16'd0);
    assign active     = !item.home_sensor;
    assign hits_inc   = hits_reg + {15'd0, active};
    assign tgt        = sat_index(item.target_index);
    assign prod       = {12'd0, tgt} * {4'd0, cfg.steps_per_index};
    assign idx_count  = prod - pos_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        dir_next   = dir_reg;
        stm_next   = stm_reg;
        done_next  = done_reg;
        pos_next   = pos_reg;
        hits_next  = hits_reg;
        phase_next = phase_reg;
        coil_next  = coil_reg;
        homed_next = homed_reg;
        err_next   = err_reg;
        do_step    = 1'b0;
        do_pos     = 1'b0;
        do_release = 1'b0;
        fin        = 1'b0;

        case (kind_t'(item.kind))
            KIND_TICK:
            begin
                case (mode_reg)
                    MODE_CROSS:
                    begin
                        fin = 1'b1;
                        if (stm_nz)
                        begin
                            do_step   = 1'b1;
                            hits_next = hits_inc;
                            fin       = done_hit;
                            if (done_hit)
                                pos_next = 16'd0;
                        end
                        if (fin)
                        begin
                            homed_next = (hits_next >= cfg.zero_count_threshold);
                            err_next   = (hits_next < cfg.zero_count_threshold);
                            do_release = 1'b1;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (stm_nz)
                        begin
                            do_step = 1'b1;
                            do_pos  = 1'b1;
                            if (active)
                            begin
                                homed_next = 1'b1;
                                err_next   = 1'b0;
                                do_release = 1'b1;
                            end
                            else if (done_hit)
                            begin
                                homed_next = 1'b0;
                                err_next   = 1'b1;
                                do_release = 1'b1;
                            end
                        end
                    end
                    MODE_NORMAL:
                    begin
                        if (stm_nz)
                        begin
                            do_step    = 1'b1;
                            do_pos     = 1'b1;
                            do_release = done_hit;
                        end
                        else
                            do_release = 1'b1;
                    end
                    MODE_STALL:
                        do_release = 1'b1;
                    default: ;
                endcase

                if (do_step)
                begin
                    phase_next = step_phase;
                    coil_next  = coil_lookup(step_phase[2:0]);
                    done_next  = step_done;
                end
                if (do_pos)
                    pos_next = step_pos;
                // release keeps coil bits 3 and 1 as just driven, forces bits 2 and 0 high
                if (do_release)
                begin
                    coil_next = (coil_next & COIL_KEEP) | COIL_RELEASE;
                    stm_next  = 16'd0;
                    mode_next = MODE_IDLE;
                end
            end
            KIND_START:
            begin
                if (item.move_steps == 16'sd0 || item.move_mode == MOVE_INVALID)
                    mode_next = MODE_IDLE;
                else
                begin
                    dir_next  = item.move_steps[15];
                    stm_next  = item.move_steps;
                    done_next = 16'd0;
                    case (move_mode_t'(item.move_mode))
                        MOVE_NORMAL: mode_next = MODE_NORMAL;
                        MOVE_SEARCH: mode_next = MODE_SEARCH;
                        MOVE_CROSS:
                        begin
                            mode_next = MODE_CROSS;
                            hits_next = 16'd0;
                        end
                        default:     mode_next = MODE_IDLE;
                    endcase
                end
            end
            KIND_INDEX:
            begin
                if (idx_count == 16'd0)
                    mode_next = MODE_IDLE;
                else
                begin
                    dir_next  = idx_count[15];
                    stm_next  = idx_count;
                    done_next = 16'd0;
                    mode_next = MODE_NORMAL;
                end
            end
            KIND_STALL:
                mode_next = MODE_STALL;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            dir_reg   <= 1'b0;
            stm_reg   <= 16'd0;
            done_reg  <= 16'd0;
            pos_reg   <= 16'd0;
            hits_reg  <= 16'd0;
            phase_reg <= PHASE_NONE;
            coil_reg  <= 4'd0;
            homed_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (en)
        begin
            mode_reg  <= mode_next;
            dir_reg   <= dir_next;
            stm_reg   <= stm_next;
            done_reg  <= done_next;
            pos_reg   <= pos_next;
            hits_reg  <= hits_next;
            phase_reg <= phase_next;
            coil_reg  <= coil_next;
            homed_reg <= homed_next;
            err_reg   <= err_next;
        end
    end

    assign result.coil_pattern = coil_next;
    assign result.motor_mode   = mode_next;
    assign result.position     = pos_next;
    assign result.homed        = homed_next;
    assign result.home_error   = err_next;
    assign result.is_idle      = (mode_next == MODE_IDLE);

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper homing controller: a directed table of
// moves, homing cases and stalls, then random move sequences under several
// threshold and index-spacing settings, checked against a motor predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import smh_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 140;
    localparam int MAX_REPORTED = 10;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } drill_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b1;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predicted motor state
    motor_mode_t mode_s;
    logic        rev_s;
    logic [15:0] steps_to_go;
    logic [15:0] steps_taken;
    logic [15:0] pos_s;
    logic [15:0] hits_s;
    logic [3:0]  phase_s;
    logic [3:0]  coil_s;
    logic        homed_s;
    logic        err_s;
    logic [15:0] thresh_s;
    logic [11:0] spi_s;

    logic [3:0]  coil_seq [8] = '{4'h6, 4'h5, 4'h4, 4'h8, 4'h0, 4'h3, 4'h2, 4'hE};

    out_item_t   want_q [$];
    drill_row_t  drill_rows [$];
    int          mismatches = 0;
    int          in_gap_pct = 0;
    int          out_stall_pct = 0;

    stepper_motion_homing_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);

    task automatic note_mismatch(string what, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
    endtask

    // ------------------------------------------------------------------------
    // motor predictor
    // ------------------------------------------------------------------------
    function automatic void half_step();
        if (!rev_s)
        begin
            if (phase_s == PHASE_NONE || phase_s >= 4'(PHASE_STEPS - 1))
                phase_s = 4'd0;
            else
                phase_s = phase_s + 4'd1;
            steps_taken = steps_taken + 16'd1;
        end
        else
        begin
            if (phase_s == PHASE_NONE || phase_s == 4'd0 || phase_s > 4'(PHASE_STEPS - 1))
                phase_s = 4'(PHASE_STEPS - 1);
            else
                phase_s = phase_s - 4'd1;
            steps_taken = steps_taken - 16'd1;
        end
        coil_s = coil_seq[phase_s[2:0]];
    endfunction

    function automatic void follow_step();
        pos_s = rev_s ? pos_s - 16'd1 : pos_s + 16'd1;
    endfunction

    function automatic void begin_move(logic [15:0] n, motor_mode_t m);
        if (n == 16'd0 || m == MODE_IDLE || m > MODE_CROSS)
        begin
            mode_s = MODE_IDLE;
            return;
        end
        rev_s = n[15];
        steps_to_go = n;
        steps_taken = 16'd0;
        if (m == MODE_CROSS)
            hits_s = 16'd0;
        mode_s = m;
    endfunction

    function automatic void motor_tick(logic sensor);
        logic active;
        logic fin;
        active = !sensor;
        case (mode_s)
            MODE_CROSS:
            begin
                fin = 1'b1;
                if (steps_to_go != 16'd0)
                begin
                    half_step();
                    if (active)
                        hits_s = hits_s + 16'd1;
                    fin = (steps_taken == steps_to_go);
                    // position is held while crossing and zeroed at the end
                    if (fin)
                    begin
                        pos_s = 16'd0;
                        steps_to_go = 16'd0;
                    end
                end
                if (fin)
                begin
                    homed_s = (hits_s >= thresh_s);
                    err_s = !homed_s;
                    mode_s = MODE_STALL;
                end
            end
            MODE_SEARCH:
            begin
                if (steps_to_go != 16'd0)
                begin
                    half_step();
                    follow_step();
                    if (active)
                    begin
                        homed_s = 1'b1;
                        err_s = 1'b0;
                        mode_s = MODE_STALL;
                    end
                    else if (steps_taken == steps_to_go)
                    begin
                        homed_s = 1'b0;
                        err_s = 1'b1;
                        mode_s = MODE_STALL;
                    end
                end
            end
            MODE_NORMAL:
            begin
                if (steps_to_go != 16'd0)
                begin
                    half_step();
                    follow_step();
                    if (steps_taken == steps_to_go)
                        mode_s = MODE_STALL;
                end
                else
                    mode_s = MODE_STALL;
            end
            default: ;
        endcase
        if (mode_s == MODE_STALL)
        begin
            coil_s = (coil_s & COIL_KEEP) | COIL_RELEASE;
            steps_to_go = 16'd0;
            mode_s = MODE_IDLE;
        end
    endfunction

    function automatic out_item_t advance_motor(in_item_t it);
        out_item_t   o;
        logic [3:0]  tgt;
        logic [31:0] prod;
        case (kind_t'(it.kind))
            KIND_TICK:
                motor_tick(it.home_sensor);
            KIND_START:
                case (move_mode_t'(it.move_mode))
                    MOVE_NORMAL: begin_move(it.move_steps, MODE_NORMAL);
                    MOVE_SEARCH: begin_move(it.move_steps, MODE_SEARCH);
                    MOVE_CROSS:  begin_move(it.move_steps, MODE_CROSS);
                    // unknown mode drops to idle like a zero count
                    default:     mode_s = MODE_IDLE;
                endcase
            KIND_INDEX:
            begin
                tgt = (int'(it.target_index) >= INDEX_COUNT) ? 4'(INDEX_COUNT - 1)
                                                             : it.target_index;
                prod = 32'(tgt) * 32'(spi_s);
                begin_move(prod[15:0] - pos_s, MODE_NORMAL);
            end
            default:
                mode_s = MODE_STALL;
        endcase
        o.coil_pattern = coil_s;
        o.motor_mode   = mode_s;
        o.position     = pos_s;
        o.homed        = homed_s;
        o.home_error   = err_s;
        o.is_idle      = (mode_s == MODE_IDLE);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic in_item_t cmd(kind_t k, logic s, logic [15:0] n, move_mode_t m,
                                     logic [3:0] t);
        in_item_t it;
        it.kind         = k;
        it.home_sensor  = s;
        it.move_steps   = n;
        it.move_mode    = m;
        it.target_index = t;
        return it;
    endfunction

    function automatic out_item_t status(logic [3:0] c, motor_mode_t m, logic [15:0] p,
                                         logic h, logic e);
        out_item_t o;
        o.coil_pattern = c;
        o.motor_mode   = m;
        o.position     = p;
        o.homed        = h;
        o.home_error   = e;
        o.is_idle      = (m == MODE_IDLE);
        return o;
    endfunction

    // called and returns at a falling edge
    task automatic push_item(in_item_t it, bit typed, out_item_t want);
        out_item_t got;
        while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = advance_motor(it);
        want_q.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (want_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] v);
        logic [31:0] kept;
        kept = (idx == REG_THRESHOLD) ? {16'd0, v[15:0]} : {20'd0, v[11:0]};
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_THRESHOLD)
            thresh_s = v[15:0];
        else
            spi_s = v[11:0];
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== kept)
            note_mismatch("register readback", int'(kept), int'(prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly well-formed moves run to completion, with stalls, restarts and noise
    task automatic random_items(int count);
        int          sent;
        int          ticks;
        int          hit_pct;
        int          roll;
        logic [31:0] raw;
        logic [15:0] n;
        in_item_t    it;
        sent = 0;
        while (sent < count)
        begin
            raw = $urandom;
            it = raw[$bits(in_item_t)-1:0];
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(99) < 15)
                    it.kind = KIND_INDEX;
                else
                begin
                    n = 16'($urandom_range(1, 24));
                    if ($urandom_range(1) == 1)
                        n = -n;
                    if ($urandom_range(19) == 0)
                        n = 16'($urandom);
                    it.kind = KIND_START;
                    it.move_steps = n;
                    it.move_mode = 2'($urandom_range(2));
                end
                hit_pct = (it.kind == KIND_START && it.move_mode == MOVE_SEARCH) ? 8
                          : $urandom_range(30, 95);
                push_item(it, 1'b0, '0);
                sent++;
                ticks = 0;
                while (mode_s != MODE_IDLE && ticks < 40 && sent < count)
                begin
                    raw = $urandom;
                    it = raw[$bits(in_item_t)-1:0];
                    roll = $urandom_range(99);
                    if (roll < 4)
                        it.kind = KIND_STALL;
                    else if (roll < 7)
                    begin
                        it.kind = KIND_START;
                        it.move_steps = 16'($urandom_range(1, 24));
                        it.move_mode = 2'($urandom_range(2));
                    end
                    else
                    begin
                        it.kind = KIND_TICK;
                        it.home_sensor = ($urandom_range(99) < hit_pct) ? 1'b0 : 1'b1;
                    end
                    push_item(it, 1'b0, '0);
                    sent++;
                    ticks++;
                end
            end
            else
            begin
                push_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        out_item_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (want_q.size() == 0)
                note_mismatch("result with nothing expected, coils", 0,
                              int'(out_data.coil_pattern));
            else
            begin
                w = want_q.pop_front();
                if (out_data.coil_pattern !== w.coil_pattern)
                    note_mismatch("coil_pattern", int'(w.coil_pattern),
                                  int'(out_data.coil_pattern));
                if (out_data.motor_mode !== w.motor_mode)
                    note_mismatch("motor_mode", int'(w.motor_mode),
                                  int'(out_data.motor_mode));
                if (out_data.position !== w.position)
                    note_mismatch("position", int'(w.position), int'(out_data.position));
                if (out_data.homed !== w.homed)
                    note_mismatch("homed", int'(w.homed), int'(out_data.homed));
                if (out_data.home_error !== w.home_error)
                    note_mismatch("home_error", int'(w.home_error),
                                  int'(out_data.home_error));
                if (out_data.is_idle !== w.is_idle)
                    note_mismatch("is_idle", int'(w.is_idle), int'(out_data.is_idle));
            end
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** stepper_motion_homing_controller: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main flow
    // ------------------------------------------------------------------------
    initial
    begin : main
        int ph;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        mode_s      = MODE_IDLE;
        rev_s       = 1'b0;
        steps_to_go = 16'd0;
        steps_taken = 16'd0;
        pos_s       = 16'd0;
        hits_s      = 16'd0;
        phase_s     = PHASE_NONE;
        coil_s      = 4'd0;
        homed_s     = 1'b0;
        err_s       = 1'b0;
        thresh_s    = THRESH_RESET;
        spi_s       = SPI_RESET;

        // idle tick, zero count and unknown mode leave the reset state alone
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b1,
                               status(4'h0, MODE_IDLE, 16'd0, 1'b0, 1'b0)});
        drill_rows.push_back('{cmd(KIND_START, 1'b0, 16'd0, MOVE_NORMAL, 4'd0), 1'b1,
                               status(4'h0, MODE_IDLE, 16'd0, 1'b0, 1'b0)});
        drill_rows.push_back('{cmd(KIND_START, 1'b0, 16'd5, MOVE_INVALID, 4'd0), 1'b1,
                               status(4'h0, MODE_IDLE, 16'd0, 1'b0, 1'b0)});
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'd3, MOVE_NORMAL, 4'd0), 1'b1,
                               status(4'h0, MODE_NORMAL, 16'd0, 1'b0, 1'b0)});
        // forward steps, the last of which finishes with coil release
        repeat (3)
            drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        // reverse move
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'hFFFE, MOVE_NORMAL, 4'd0), 1'b0, '0});
        repeat (2)
            drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        // largest counts both ways, restart while moving, search finds home
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'h7FFF, MOVE_NORMAL, 4'hF), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'h8000, MOVE_SEARCH, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b0, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        // search runs out of budget
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'd2, MOVE_SEARCH, 4'd0), 1'b0, '0});
        repeat (2)
            drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'hFFFF, MOVE_INVALID, 4'hF),
                                   1'b0, '0});
        // cross with too few sensor hits
        drill_rows.push_back('{cmd(KIND_START, 1'b1, 16'd3, MOVE_CROSS, 4'd0), 1'b0, '0});
        repeat (3)
            drill_rows.push_back('{cmd(KIND_TICK, 1'b0, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        // stall request from idle, then index moves at both ends
        drill_rows.push_back('{cmd(KIND_STALL, 1'b0, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_INDEX, 1'b1, 16'd0, MOVE_NORMAL, 4'hF), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_STALL, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_TICK, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});
        drill_rows.push_back('{cmd(KIND_INDEX, 1'b1, 16'd0, MOVE_NORMAL, 4'd0), 1'b0, '0});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (drill_rows[i])
            push_item(drill_rows[i].item, drill_rows[i].typed, drill_rows[i].want);
        settle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(REG_THRESHOLD, 32'd0);
                    write_reg(REG_STEPS_PER_INDEX, 32'd1);
                end
                2:
                begin
                    write_reg(REG_THRESHOLD, 32'd65535);
                    write_reg(REG_STEPS_PER_INDEX, 32'd4095);
                end
                3:
                begin
                    write_reg(REG_THRESHOLD, 32'd6);
                    write_reg(REG_STEPS_PER_INDEX, 32'd3);
                end
                4:
                begin
                    write_reg(REG_THRESHOLD, 32'd12);
                    write_reg(REG_STEPS_PER_INDEX, 32'd2);
                end
                5:
                begin
                    write_reg(REG_THRESHOLD, 32'd4);
                    write_reg(REG_STEPS_PER_INDEX, 32'd5);
                end
                default: ;
            endcase
            case (ph % 4)
                1:
                begin
                    in_gap_pct = 70;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_gap_pct = 0;
                    out_stall_pct = 70;
                end
                3:
                begin
                    in_gap_pct = 9;
                    out_stall_pct = 9;
                end
                default:
                begin
                    in_gap_pct = 0;
                    out_stall_pct = 0;
                end
            endcase
            random_items(PHASE_ITEMS);
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && want_q.size() == 0)
            $display("** stepper_motion_homing_controller: PASSED **");
        else
            $display("** stepper_motion_homing_controller: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/smh_pkg.sv
sv/smh_cfg.sv
sv/smh_core.sv
sv/stepper_motion_homing_controller.sv
verif/testbench.sv
